// File: src/chd_pkg.sv
package chd_pkg;

    localparam int NUM_SYMBOLS_DEF     = 256;
    localparam int MAX_CODE_LENGTH_DEF = 15;

    localparam int OP_W    = 2;
    localparam int LEN_W   = 4;
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 16;
    localparam int BITS_W  = 5;
    localparam int LEN_SLOTS = 16;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD  = 2'd1;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

    typedef struct packed {
        logic             load;
        logic             build;
        logic             decode;
        logic [LEN_W-1:0] code_length;
        logic             code_bit;
    } chd_cmd_t;

endpackage

// File: src/chd_build.sv
module chd_build import chd_pkg::*; #(
    parameter int NUM_SYMBOLS     = NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  chd_cmd_t                         cmd,
    output logic                             busy,
    output logic                             sort_we,
    output logic [$clog2(NUM_SYMBOLS)-1:0]   sort_addr,
    output logic [SYM_W-1:0]                 sort_data,
    input  logic [LEN_W-1:0]                 cnt_addr,
    output logic [$clog2(NUM_SYMBOLS+1)-1:0] cnt_data
);

    localparam int AW = $clog2(NUM_SYMBOLS);
    localparam int CW = $clog2(NUM_SYMBOLS + 1);
    localparam int LEN_LAST_I = (MAX_CODE_LENGTH < LEN_SLOTS - 1) ? MAX_CODE_LENGTH
                                                                  : LEN_SLOTS - 1;
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LEN_LAST_I);
    localparam logic [CW-1:0]    NUM_CW   = CW'(NUM_SYMBOLS);

    typedef enum logic [1:0] {B_IDLE, B_SCAN, B_DRAIN} state_t;

    state_t           state_reg;
    logic [CW-1:0]    loaded_reg;
    logic [AW-1:0]    scan_reg;
    logic [LEN_W-1:0] len_reg;
    logic             rd_valid_reg;
    logic             rd_last_reg;
    logic [AW-1:0]    rd_sym_reg;
    logic [LEN_W-1:0] rd_len_reg;
    logic [LEN_W-1:0] rd_data_reg;
    logic [CW-1:0]    acc_reg;
    logic [CW-1:0]    acc_next;
    logic [CW-1:0]    pos_reg;
    logic [CW-1:0]    count_reg [LEN_SLOTS];
    logic [LEN_W-1:0] length_mem [NUM_SYMBOLS];

    logic scan_last;
    logic hit;
    logic load_ok;

    assign load_ok   = cmd.load && (loaded_reg < NUM_CW);
    assign scan_last = ((CW'(scan_reg) + CW'(1)) == loaded_reg);
    assign hit       = rd_valid_reg && (rd_data_reg == rd_len_reg);
    assign acc_next  = acc_reg + CW'(hit);

    assign busy      = (state_reg != B_IDLE);
    assign sort_we   = hit && (pos_reg < NUM_CW);
    assign sort_addr = pos_reg[AW-1:0];
    assign sort_data = SYM_W'(rd_sym_reg);
    assign cnt_data  = count_reg[cnt_addr];

    always_ff @(posedge aclk) begin
        if (load_ok) begin
            length_mem[loaded_reg[AW-1:0]] <= cmd.code_length;
        end
        rd_data_reg <= length_mem[scan_reg];
        rd_last_reg <= scan_last;
        rd_sym_reg  <= scan_reg;
        rd_len_reg  <= len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            loaded_reg   <= '0;
            scan_reg     <= '0;
            len_reg      <= '0;
            rd_valid_reg <= 1'b0;
            acc_reg      <= '0;
            pos_reg      <= '0;
            for (int i = 0; i < LEN_SLOTS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            rd_valid_reg <= (state_reg == B_SCAN);
            if (rd_valid_reg) begin
                if (hit) begin
                    pos_reg <= pos_reg + CW'(1);
                end
                if (rd_last_reg) begin
                    count_reg[rd_len_reg] <= acc_next;
                    acc_reg <= '0;
                end else begin
                    acc_reg <= acc_next;
                end
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (load_ok) begin
                        loaded_reg <= loaded_reg + CW'(1);
                    end
                    if (cmd.build) begin
                        for (int i = 0; i < LEN_SLOTS; i++) begin
                            count_reg[i] <= '0;
                        end
                        pos_reg    <= '0;
                        acc_reg    <= '0;
                        scan_reg   <= '0;
                        len_reg    <= LEN_W'(1);
                        if (loaded_reg != '0) begin
                            state_reg <= B_SCAN;
                        end
                    end
                end
                B_SCAN: begin
                    if (scan_last) begin
                        scan_reg <= '0;
                        if (len_reg == LEN_LAST) begin
                            state_reg <= B_DRAIN;
                        end else begin
                            len_reg <= len_reg + LEN_W'(1);
                        end
                    end else begin
                        scan_reg <= scan_reg + AW'(1);
                    end
                end
                B_DRAIN: begin
                    loaded_reg <= '0;
                    state_reg  <= B_IDLE;
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/chd_decode.sv
module chd_decode import chd_pkg::*; #(
    parameter int NUM_SYMBOLS     = NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             restart,
    input  logic                             bit_en,
    input  logic                             code_bit,
    output logic                             can_accept,
    input  logic                             sort_we,
    input  logic [$clog2(NUM_SYMBOLS)-1:0]   sort_addr,
    input  logic [SYM_W-1:0]                 sort_data,
    output logic [LEN_W-1:0]                 cnt_addr,
    input  logic [$clog2(NUM_SYMBOLS+1)-1:0] cnt_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [SYM_W-1:0]                 m_symbol,
    output logic                             m_code_error
);

    localparam int AW = $clog2(NUM_SYMBOLS);
    localparam int CW = $clog2(NUM_SYMBOLS + 1);
    localparam logic [BITS_W-1:0] MAX_BITS = BITS_W'(MAX_CODE_LENGTH);
    localparam logic [CW:0]       NUM_IDX  = (CW+1)'(NUM_SYMBOLS);

    logic [CODE_W-1:0] code_reg;
    logic [BITS_W-1:0] bits_reg;
    logic [CODE_W-1:0] first_reg;
    logic [CW-1:0]     offset_reg;
    logic              pend_reg;
    logic              m_valid_reg;
    logic [SYM_W-1:0]  m_symbol_reg;
    logic              m_code_error_reg;
    logic [SYM_W-1:0]  rd_sym_reg;
    logic [SYM_W-1:0]  sorted_mem [NUM_SYMBOLS];

    logic [CODE_W-1:0] code_next;
    logic [BITS_W-1:0] bits_next;
    logic [CW-1:0]     cnt;
    logic [CODE_W-1:0] diff;
    logic [CW:0]       idx;
    logic              hit;
    logic              in_range;
    logic              err;

    assign code_next = {code_reg[CODE_W-2:0], code_bit};
    assign bits_next = bits_reg + BITS_W'(1);
    assign cnt_addr  = bits_next[LEN_W-1:0];
    assign cnt       = bits_next[BITS_W-1] ? '0 : cnt_data;
    assign diff      = code_next - first_reg;
    assign hit       = (code_next >= first_reg) && (diff < CODE_W'(cnt));
    assign idx       = (CW+1)'(offset_reg) + (CW+1)'(diff[CW-1:0]);
    assign in_range  = (idx < NUM_IDX);
    assign err       = (bits_next >= MAX_BITS) || (bits_next == '0);

    assign can_accept   = !pend_reg && (!m_valid_reg || m_ready);
    assign m_valid      = m_valid_reg;
    assign m_symbol     = m_symbol_reg;
    assign m_code_error = m_code_error_reg;

    always_ff @(posedge aclk) begin
        if (sort_we) begin
            sorted_mem[sort_addr] <= sort_data;
        end
        rd_sym_reg <= sorted_mem[idx[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg    <= '0;
            bits_reg    <= '0;
            first_reg   <= '0;
            offset_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pend_reg) begin
                pend_reg         <= 1'b0;
                m_valid_reg      <= 1'b1;
                m_symbol_reg     <= rd_sym_reg;
                m_code_error_reg <= 1'b0;
            end else if (bit_en && (hit || err) && !(hit && in_range)) begin
                m_valid_reg      <= 1'b1;
                m_symbol_reg     <= '0;
                m_code_error_reg <= !hit;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (restart) begin
                code_reg   <= '0;
                bits_reg   <= '0;
                first_reg  <= '0;
                offset_reg <= '0;
            end
            if (bit_en) begin
                if (hit || err) begin
                    code_reg   <= '0;
                    bits_reg   <= '0;
                    first_reg  <= '0;
                    offset_reg <= '0;
                    if (hit && in_range) begin
                        pend_reg <= 1'b1;
                    end
                end else begin
                    code_reg   <= code_next;
                    bits_reg   <= bits_next;
                    offset_reg <= offset_reg + cnt;
                    first_reg  <= (first_reg + CODE_W'(cnt)) << 1;
                end
            end
        end
    end

endmodule

// File: src/canonical_huffman_decoder_top.sv
// Canonical Huffman decoder, DEFLATE style.
// Input channel s_valid/s_ready carries one beat per command in s_op:
//   load  - store s_code_length as the length of the next symbol (0 = unused);
//           loads past NUM_SYMBOLS symbols are dropped.
//   build - restart the bit decoder, count codes per length and fill the symbol
//           table, then begin a fresh set of lengths.
//   decode - shift s_code_bit in, most significant bit first.
// Result channel m_valid/m_ready carries one beat per finished code: the symbol,
// or m_code_error high with symbol 0 once MAX_CODE_LENGTH bits match nothing.
// Throughput: one decode bit per cycle while no build runs and the receiver
// keeps up; a bit that completes a code holds off the next beat while its symbol
// is read from a synchronous table and moved on to the output register, where
// an error is written directly. A build makes one length memory read per symbol
// loaded for each code length from 1 to min(MAX_CODE_LENGTH,15).
// Reset clears all control state and the code counts; no clearing pass is run.
// While the receiver stalls, a waiting result holds and further input beats
// are held off until the output register frees.
module canonical_huffman_decoder_top import chd_pkg::*; #(
    parameter int NUM_SYMBOLS     = NUM_SYMBOLS_DEF,
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [OP_W-1:0]  s_op,
    input  logic [LEN_W-1:0] s_code_length,
    input  logic             s_code_bit,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [SYM_W-1:0] m_symbol,
    output logic             m_code_error
);

    localparam int AW = $clog2(NUM_SYMBOLS);
    localparam int CW = $clog2(NUM_SYMBOLS + 1);

    chd_cmd_t         cmd;
    logic             accept;
    logic             build_busy;
    logic             dec_ok;
    logic             sort_we;
    logic [AW-1:0]    sort_addr;
    logic [SYM_W-1:0] sort_data;
    logic [LEN_W-1:0] cnt_addr;
    logic [CW-1:0]    cnt_data;

    assign s_ready = !build_busy && dec_ok;
    assign accept  = s_valid && s_ready;

    assign cmd.load        = accept && (s_op == OP_LOAD);
    assign cmd.build       = accept && (s_op == OP_BUILD);
    assign cmd.decode      = accept && (s_op == OP_DECODE);
    assign cmd.code_length = s_code_length;
    assign cmd.code_bit    = s_code_bit;

    chd_build #(
        .NUM_SYMBOLS     (NUM_SYMBOLS),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_build (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .busy      (build_busy),
        .sort_we   (sort_we),
        .sort_addr (sort_addr),
        .sort_data (sort_data),
        .cnt_addr  (cnt_addr),
        .cnt_data  (cnt_data)
    );

    chd_decode #(
        .NUM_SYMBOLS     (NUM_SYMBOLS),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .restart      (cmd.build),
        .bit_en       (cmd.decode),
        .code_bit     (cmd.code_bit),
        .can_accept   (dec_ok),
        .sort_we      (sort_we),
        .sort_addr    (sort_addr),
        .sort_data    (sort_data),
        .cnt_addr     (cnt_addr),
        .cnt_data     (cnt_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_symbol     (m_symbol),
        .m_code_error (m_code_error)
    );

endmodule
